[sv/ovus_pkg.sv]
// Shared types and constants for the overwriting undo stack.
package ovus_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CAP_W          = 5;
    localparam int CNT_W          = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_REPLACE = 2'd3
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the request and start the top-entry read
        logic execute;  // apply the operation and load the result register
    } t_ctrl_cmd;

endpackage

[sv/ovus_in_if.sv]
// Request channel: command and word with valid/ready handshake.
interface ovus_in_if #(
    parameter int DATA_WIDTH = ovus_pkg::DATA_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [DATA_WIDTH-1:0] value_in;

    modport source (output valid, output cmd, output value_in, input ready);
    modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

[sv/ovus_out_if.sv]
// Result channel: returned word, flags and stack status with valid/ready handshake.
interface ovus_out_if #(
    parameter int DATA_WIDTH = ovus_pkg::DATA_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic [DATA_WIDTH-1:0]       value_out;
    logic                        value_valid;
    logic                        evicted_oldest;
    logic                        op_ignored;
    logic [ovus_pkg::CNT_W-1:0]  entry_count;
    logic                        is_empty;
    logic                        is_full;

    modport source (output valid, output value_out, output value_valid,
                    output evicted_oldest, output op_ignored, output entry_count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input value_out, input value_valid,
                    input evicted_oldest, input op_ignored, input entry_count,
                    input is_empty, input is_full, output ready);
endinterface

[sv/ovus_ctrl.sv]
// Controller: sequences capture and execute and owns the result valid flag.
module ovus_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output ovus_pkg::t_ctrl_cmd o_cmd
);
    import ovus_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.execute = w_slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Set on a new result, drop once the waiting result transfers
    always_comb begin
        if (o_cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/ovus_dp.sv]
// Datapath: entry ring, pointers, capacity register and result register.
module ovus_dp #(
    parameter int DEPTH      = ovus_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ovus_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ovus_pkg::t_ctrl_cmd        i_cmd,
    input  logic                       i_cfg_we,
    input  logic [ovus_pkg::CAP_W-1:0] i_cfg_wdata,
    input  logic [1:0]                 i_req_cmd,
    input  logic [DATA_WIDTH-1:0]      i_req_value,
    output logic [DATA_WIDTH-1:0]      o_value_out,
    output logic                       o_value_valid,
    output logic                       o_evicted_oldest,
    output logic                       o_op_ignored,
    output logic [ovus_pkg::CNT_W-1:0] o_entry_count,
    output logic                       o_is_empty,
    output logic                       o_is_full
);
    import ovus_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int EXT_W   = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
    localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
    localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_MAX[CAP_W-1:0];

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic [CAP_W-1:0]      r_cap_reg;
    logic [IDX_W-1:0]      r_top;
    logic [IDX_W-1:0]      r_oldest;
    logic [CNT_W-1:0]      r_count;
    t_cmd                  r_op;
    logic [DATA_WIDTH-1:0] r_val;

    logic [IDX_W-1:0]      n_top;
    logic [IDX_W-1:0]      n_oldest;
    logic [CNT_W-1:0]      n_count;
    logic [DATA_WIDTH-1:0] n_value_out;
    logic                  n_value_valid;
    logic                  n_evicted;
    logic                  n_ignored;
    logic                  w_mem_we;
    logic [IDX_W-1:0]      w_mem_addr;

    logic [CAP_W-1:0]      w_cap;
    logic [EXT_W-1:0]      w_cap_ext;
    logic [IDX_W-1:0]      w_cap_last;
    logic [IDX_W-1:0]      w_top_inc;
    logic [IDX_W-1:0]      w_oldest_inc;
    logic [EXT_W-1:0]      w_top_ext;
    logic [EXT_W-1:0]      w_oldest_ext;

    // Zero acts as one, anything above the ring size as the ring size
    always_comb begin
        if (r_cap_reg == '0) begin
            w_cap = CAP_W'(1);
        end else if (r_cap_reg > CAP_MAX_V) begin
            w_cap = CAP_MAX_V;
        end else begin
            w_cap = r_cap_reg;
        end
    end

    assign w_cap_ext    = EXT_W'(w_cap);
    assign w_cap_last   = IDX_W'(w_cap_ext - EXT_W'(1));
    assign w_top_ext    = EXT_W'(r_top) + EXT_W'(1);
    assign w_oldest_ext = EXT_W'(r_oldest) + EXT_W'(1);
    assign w_top_inc    = (w_top_ext >= w_cap_ext) ? '0 : IDX_W'(w_top_ext);
    assign w_oldest_inc = (w_oldest_ext >= w_cap_ext) ? '0 : IDX_W'(w_oldest_ext);

    always_comb begin
        n_top         = r_top;
        n_oldest      = r_oldest;
        n_count       = r_count;
        n_value_out   = '0;
        n_value_valid = 1'b0;
        n_evicted     = 1'b0;
        n_ignored     = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_addr    = r_top;
        if (r_op == CMD_PUSH) begin
            n_top      = w_top_inc;
            w_mem_we   = 1'b1;
            w_mem_addr = w_top_inc;
            if (r_count == '0) begin
                n_oldest = w_top_inc;
                n_count  = CNT_W'(1);
            end else if (r_count < w_cap) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_oldest  = w_oldest_inc;
                n_evicted = 1'b1;
            end
        end else if (r_count == '0) begin
            n_ignored = 1'b1;
        end else begin
            case (r_op)
                CMD_POP: begin
                    n_value_out   = r_rd_data;
                    n_value_valid = 1'b1;
                    n_top         = (r_top == '0) ? w_cap_last : r_top - IDX_W'(1);
                    n_count       = r_count - CNT_W'(1);
                end
                CMD_PEEK: begin
                    n_value_out   = r_rd_data;
                    n_value_valid = 1'b1;
                end
                default: begin
                    w_mem_we = 1'b1;
                end
            endcase
        end
    end

    // Entry ring: one write port, one registered read at the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && w_mem_we) begin
            r_mem[w_mem_addr] <= r_val;
        end
        if (i_cmd.capture) begin
            r_rd_data <= r_mem[r_top];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_cmd'(i_req_cmd);
            r_val <= i_req_value;
        end
        if (i_cmd.execute) begin
            o_value_out      <= n_value_out;
            o_value_valid    <= n_value_valid;
            o_evicted_oldest <= n_evicted;
            o_op_ignored     <= n_ignored;
            o_entry_count    <= n_count;
            o_is_empty       <= (n_count == '0);
            o_is_full        <= (n_count == w_cap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_reg <= CAP_RESET;
            r_top     <= '0;
            r_oldest  <= '0;
            r_count   <= '0;
        end else if (i_cfg_we) begin
            r_cap_reg <= i_cfg_wdata;
            r_top     <= '0;
            r_oldest  <= '0;
            r_count   <= '0;
        end else if (i_cmd.execute) begin
            r_top    <= n_top;
            r_oldest <= n_oldest;
            r_count  <= n_count;
        end
    end

endmodule

[sv/overwriting_undo_stack_unit.sv]
// Top level of the overwriting undo stack: controller plus datapath.
// Bounded LIFO undo store in a ring of DEPTH words. Each request carries a
// command (push, pop, peek, replace) and a word; each produces exactly one
// result with the returned word, a valid flag, eviction and ignore flags, and
// the entry count with empty and full after the operation. A push on a full
// stack drops the oldest entry. Pop, peek and replace on an empty stack change
// nothing and report op_ignored. A request is handled in a capture step and
// an execute step: the top entry is read from the ring with a registered
// read at the request transfer, and the execute step applies the operation
// and loads the result register once that register is free or being emptied.
// One request is in work at a time; a new request is taken while the
// previous result still waits in the output register, and it holds in the
// execute step until that result transfers. Writing the capacity register
// empties the stack; write it only while no request is in work. Capacity zero
// acts as one, and values above DEPTH act as DEPTH. The ring needs no clearing
// pass after reset: an entry is always written before it can be read.
module overwriting_undo_stack_unit #(
    parameter int DEPTH      = ovus_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ovus_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ovus_pkg::CAP_W-1:0] i_cfg_wdata,
    ovus_in_if.sink                    i_req,
    ovus_out_if.source                 o_rsp
);
    import ovus_pkg::*;

    t_ctrl_cmd w_cmd;

    // Sequence each request: capture on transfer, execute when the result
    // register is free or being emptied
    ovus_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    // Hold the ring, pointers, capacity and the result payload
    ovus_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_cmd        (i_req.cmd),
        .i_req_value      (i_req.value_in),
        .o_value_out      (o_rsp.value_out),
        .o_value_valid    (o_rsp.value_valid),
        .o_evicted_oldest (o_rsp.evicted_oldest),
        .o_op_ignored     (o_rsp.op_ignored),
        .o_entry_count    (o_rsp.entry_count),
        .o_is_empty       (o_rsp.is_empty),
        .o_is_full        (o_rsp.is_full)
    );

endmodule

[verif/overwriting_undo_stack_unit_test.sv]
// Testbench for the overwriting undo stack: directed and random traffic checked against a predictor.
`timescale 1ns / 100ps

module overwriting_undo_stack_unit_test;
    import ovus_pkg::*;

    // One result of the stack, field for field as the output channel carries it.
    typedef struct packed {
        logic [DATA_WIDTH_DEF-1:0] word;
        logic                      word_valid;
        logic                      evicted;
        logic                      ignored;
        logic [CNT_W-1:0]          count;
        logic                      empty;
        logic                      full;
    } t_stack_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    ovus_in_if  #(.DATA_WIDTH(DATA_WIDTH_DEF)) req_if ();
    ovus_out_if #(.DATA_WIDTH(DATA_WIDTH_DEF)) rsp_if ();

    overwriting_undo_stack_unit #(
        .DEPTH      (DEPTH_DEF),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #2 i_clk = ~i_clk;

    // Predicted contents of the ring and its bookkeeping. The oldest pointer
    // never shows on the outputs, so only top and count are tracked.
    logic [DATA_WIDTH_DEF-1:0] ring_words [DEPTH_DEF];
    int unsigned               top_slot   = 0;
    int unsigned               held_words = 0;
    logic [CAP_W-1:0]          cap_reg    = CAP_RESET;

    t_stack_result pending_results [$];   // results still owed by the block, oldest first
    int            errors     = 0;

    // Idle-cycle limits per transfer, one per side; phases change them.
    int unsigned   tx_gap_max = 3;
    int unsigned   rx_gap_max = 3;

    // Long receiver hold-off: main flow posts a length, the hold-off process counts it.
    int unsigned   hold_len   = 0;
    logic          rx_hold    = 1'b0;

    // Apply one operation to the predicted stack and return the result it must produce.
    function automatic t_stack_result stack_apply_op(t_cmd op, logic [DATA_WIDTH_DEF-1:0] word);
        t_stack_result r;
        int unsigned   cap;
        r = '0;
        // Register zero behaves as one, anything past the ring depth as the full ring.
        cap = (cap_reg == '0) ? 1 :
              ((int'(cap_reg) > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg));
        if (op == CMD_PUSH) begin
            top_slot = (top_slot + 1 >= cap) ? 0 : top_slot + 1;
            ring_words[top_slot] = word;
            if (held_words < cap) begin
                held_words++;
            end else begin
                // Full ring: the oldest word is overwritten, the count holds.
                r.evicted = 1'b1;
            end
        end else if (held_words == 0) begin
            // Pop, peek and replace on an empty stack leave everything alone.
            r.ignored = 1'b1;
        end else if (op == CMD_POP) begin
            r.word       = ring_words[top_slot];
            r.word_valid = 1'b1;
            top_slot     = (top_slot == 0) ? cap - 1 : top_slot - 1;
            held_words--;
        end else if (op == CMD_PEEK) begin
            r.word       = ring_words[top_slot];
            r.word_valid = 1'b1;
        end else begin
            ring_words[top_slot] = word;
        end
        r.count = CNT_W'(held_words);
        r.empty = (held_words == 0);
        r.full  = (held_words == cap);
        return r;
    endfunction

    function automatic void check_field(string name, logic [DATA_WIDTH_DEF-1:0] want,
                                        logic [DATA_WIDTH_DEF-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Offer one request, holding it until the block takes it, then record the
    // result it owes. Called at a rising edge; valid stays high between
    // back-to-back requests so it is never lowered and raised in one step.
    task automatic send_op(t_cmd op, logic [DATA_WIDTH_DEF-1:0] word);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.cmd      <= op;
        req_if.value_in <= word;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pending_results.push_back(stack_apply_op(op, word));
    endtask

    // Drain everything in flight, let the block settle, then write the
    // capacity. A write also empties the stack.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_reg    = cap;
        top_slot   = 0;
        held_words = 0;
    endtask

    // Pop, peek and replace on an empty stack at the reset capacity, then a
    // single push of all zeros read back by peek and pop.
    task automatic test_empty_stack();
        send_op(CMD_POP,     32'h1234_5678);
        send_op(CMD_PEEK,    32'hFFFF_FFFF);
        send_op(CMD_REPLACE, 32'hA5A5_A5A5);
        send_op(CMD_PUSH,    32'h0000_0000);
        send_op(CMD_PEEK,    32'hFFFF_FFFF);
        send_op(CMD_POP,     32'h0000_0000);
    endtask

    // Fill a small ring, push past full to evict, replace the top, and pop
    // down through empty.
    task automatic test_fill_and_evict();
        write_capacity(5'd3);
        send_op(CMD_PUSH,    32'h0000_0001);
        send_op(CMD_PUSH,    32'h8000_0000);
        send_op(CMD_PUSH,    32'h7FFF_FFFF);
        send_op(CMD_PUSH,    32'hFFFF_FFFF);
        send_op(CMD_PEEK,    32'h0000_0000);
        send_op(CMD_REPLACE, 32'h0000_0000);
        send_op(CMD_POP,     32'h5555_5555);
        send_op(CMD_POP,     32'h0000_0000);
        send_op(CMD_POP,     32'h0000_0000);
        send_op(CMD_POP,     32'h0000_0000);
    endtask

    // Capacity zero must act as a ring of one.
    task automatic test_capacity_clamp();
        write_capacity(5'd0);
        send_op(CMD_PUSH, 32'hFFFF_FFFF);
        send_op(CMD_PUSH, 32'h0000_0001);
        send_op(CMD_POP,  32'h0000_0000);
        send_op(CMD_PEEK, 32'h0000_0000);
    endtask

    // Random operations at one capacity; push_pct steers the fill level.
    task automatic test_random_traffic(logic [CAP_W-1:0] cap, int unsigned n_ops,
                                       int unsigned push_pct);
        int unsigned               roll;
        t_cmd                      op;
        logic [DATA_WIDTH_DEF-1:0] word;
        write_capacity(cap);
        repeat (n_ops) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
                op = CMD_PUSH;
            end else begin
                case ($urandom_range(0, 3))
                    0, 1:    op = CMD_POP;
                    2:       op = CMD_PEEK;
                    default: op = CMD_REPLACE;
                endcase
            end
            case ($urandom_range(0, 9))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            send_op(op, word);
        end
    endtask

    // Hold the result side off while requests keep coming, so the block fills
    // and stalls its input; then pause until everything is back and resume.
    task automatic test_output_backpressure();
        write_capacity(5'd16);
        tx_gap_max = 0;
        rx_gap_max = 0;
        hold_len  <= 40;
        repeat (12) send_op(CMD_PUSH, $urandom);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) send_op(CMD_POP, $urandom);
        repeat (4) send_op(CMD_PEEK, $urandom);
    endtask

    // Result side: check each transfer against the oldest prediction and
    // drive ready from the per-transfer stall and the long hold-off.
    initial begin : result_sink
        int unsigned   rx_wait;
        t_stack_result got;
        t_stack_result want;
        rx_wait = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                got.word       = rsp_if.value_out;
                got.word_valid = rsp_if.value_valid;
                got.evicted    = rsp_if.evicted_oldest;
                got.ignored    = rsp_if.op_ignored;
                got.count      = rsp_if.entry_count;
                got.empty      = rsp_if.is_empty;
                got.full       = rsp_if.is_full;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("value_out",      want.word,       got.word);
                    check_field("value_valid",    DATA_WIDTH_DEF'(want.word_valid),
                                DATA_WIDTH_DEF'(got.word_valid));
                    check_field("evicted_oldest", DATA_WIDTH_DEF'(want.evicted),
                                DATA_WIDTH_DEF'(got.evicted));
                    check_field("op_ignored",     DATA_WIDTH_DEF'(want.ignored),
                                DATA_WIDTH_DEF'(got.ignored));
                    check_field("entry_count",    DATA_WIDTH_DEF'(want.count),
                                DATA_WIDTH_DEF'(got.count));
                    check_field("is_empty",       DATA_WIDTH_DEF'(want.empty),
                                DATA_WIDTH_DEF'(got.empty));
                    check_field("is_full",        DATA_WIDTH_DEF'(want.full),
                                DATA_WIDTH_DEF'(got.full));
                end
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (rx_hold || i_rst_n !== 1'b1) begin
                rsp_if.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rsp_if.ready <= 1'b0;
                rx_wait--;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Count out a posted hold-off on the result side.
    initial begin : hold_off
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                n = hold_len;
                hold_len <= 0;
                rx_hold  <= 1'b1;
                repeat (n) @(posedge i_clk);
                rx_hold  <= 1'b0;
            end
        end
    end

    // Main flow: reset once, then every test in turn.
    initial begin : main_flow
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        req_if.valid    <= 1'b0;
        req_if.cmd      <= CMD_PUSH;
        req_if.value_in <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stack();
        test_fill_and_evict();
        test_capacity_clamp();

        // Vary capacity and idling: busy and idle sides, both, and neither.
        tx_gap_max = 17; rx_gap_max = 17;
        test_random_traffic(5'd16, 150, 60);
        tx_gap_max = 0;  rx_gap_max = 0;
        test_random_traffic(5'd1, 80, 40);
        tx_gap_max = 5;  rx_gap_max = 17;
        test_random_traffic(5'd31, 120, 55);
        tx_gap_max = 17; rx_gap_max = 0;
        test_random_traffic(5'd5, 110, 45);
        tx_gap_max = 0;  rx_gap_max = 3;
        test_random_traffic(5'd15, 120, 65);
        tx_gap_max = 17; rx_gap_max = 17;
        test_random_traffic(5'd0, 50, 50);
        tx_gap_max = 2;  rx_gap_max = 2;
        test_random_traffic(CAP_W'($urandom_range(2, 14)), 60, 50);

        test_output_backpressure();

        // Drain, then wait so the block can show any stray result.
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[overwriting_undo_stack_unit.f]
sv/ovus_pkg.sv
sv/ovus_in_if.sv
sv/ovus_out_if.sv
sv/ovus_ctrl.sv
sv/ovus_dp.sv
sv/overwriting_undo_stack_unit.sv
verif/overwriting_undo_stack_unit_test.sv
